### src/ctg_pkg.sv
`timescale 1ns / 1ps

package ctg_pkg;

  localparam int NUM_MOTORS_DEF   = 6;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int MOTOR_W  = 4;
  localparam int POS_W    = 18;
  localparam int VEL_W    = 32;
  localparam int PHASE_W  = 32;
  localparam int TRIG_W   = 16;
  localparam int XY_W     = 20;
  localparam int Z_W      = 32;
  localparam int GAIN_W   = 20;
  localparam int AMP_CFG_W = 16;

  localparam int ATAN_IDX_W = 5;
  localparam int CORDIC_X0  = 19898;
  localparam int TRIG_MAX   = 32767;

  // shared multiplier operand and product widths
  localparam int MUL_W  = 22;
  localparam int PROD_W = 2 * MUL_W;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PHASE_STEP    = 3'd0,
    CFG_HARMONIC_MODE = 3'd1,
    CFG_BASE_AMP      = 3'd2,
    CFG_AMP_DEC       = 3'd3,
    CFG_VEL_GAIN      = 3'd4
  } cfg_reg_t;

  localparam logic [31:0]        PHASE_STEP_RST = 32'd2147484;
  localparam logic               HARMONIC_RST   = 1'b0;
  localparam logic signed [15:0] BASE_AMP_RST   = 16'sd5000;
  localparam logic signed [15:0] AMP_DEC_RST    = 16'sd500;
  localparam logic [19:0]        VEL_GAIN_RST   = 20'd41175;

  // CORDIC result handed to the sequencer
  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] cos_val;
    logic signed [TRIG_W-1:0] sin_val;
  } ctg_trig_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [Z_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] r;
    unique case (idx)
      5'd0:    r = 32'sh20000000;
      5'd1:    r = 32'sh12E4051D;
      5'd2:    r = 32'sh09FB385B;
      5'd3:    r = 32'sh051111D4;
      5'd4:    r = 32'sh028B0D43;
      5'd5:    r = 32'sh0145D7E1;
      5'd6:    r = 32'sh00A2F61E;
      5'd7:    r = 32'sh00517C55;
      5'd8:    r = 32'sh0028BE53;
      5'd9:    r = 32'sh00145F2F;
      5'd10:   r = 32'sh000A2F98;
      5'd11:   r = 32'sh000517CC;
      5'd12:   r = 32'sh00028BE6;
      5'd13:   r = 32'sh000145F3;
      5'd14:   r = 32'sh0000A2F9;
      5'd15:   r = 32'sh0000517C;
      5'd16:   r = 32'sh000028BE;
      5'd17:   r = 32'sh0000145F;
      5'd18:   r = 32'sh00000A2F;
      5'd19:   r = 32'sh00000517;
      5'd20:   r = 32'sh0000028B;
      5'd21:   r = 32'sh00000145;
      5'd22:   r = 32'sh000000A2;
      5'd23:   r = 32'sh00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### src/cosine_trajectory_generator.sv
`timescale 1ns / 1ps

// Cosine trajectory generator. Each input transaction is one control tick (tdata bit 0 =
// restart); for a running trajectory it yields NUM_MOTORS output transactions, motors in
// increasing order, tlast on the final motor. A tick accepted after the trajectory has
// finished, without restart, yields nothing. Sine and cosine come from one iterative CORDIC
// unit, two rotations when the third harmonic is on. All products go through one shared
// 22 x 22 multiplier: a set-up per tick (sums, gain multiply), then per motor three
// multiplies, an accumulate and rounding/saturation; a stall on the output side holds the
// tick. s_tready is high only while no tick is in progress; the final result may still sit
// in the output register when the next tick is taken. Configuration writes belong between
// ticks.
module cosine_trajectory_generator
  import ctg_pkg::*;
#(
  parameter int NUM_MOTORS   = NUM_MOTORS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [0] restart
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [55:0]           m_tdata,   // [3:0] motor_index, [21:4] position,
                                           // [53:22] velocity
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CS_W     = 18;
  localparam int GS_W     = 39;
  localparam int GS_LO_W  = 19;
  localparam int AMP_W    = 21;
  localparam int PPROD_W  = 38;
  localparam int ACC_W    = 60;
  localparam int PRND_W   = 40;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_COS1 = 11'b000_0000_0010,
    S_COS3 = 11'b000_0000_0100,
    S_SUM  = 11'b000_0000_1000,
    S_GAIN = 11'b000_0001_0000,
    S_GS   = 11'b000_0010_0000,
    S_MPOS = 11'b000_0100_0000,
    S_MHI  = 11'b000_1000_0000,
    S_MLO  = 11'b001_0000_0000,
    S_ACC  = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration
  logic [31:0]                  phase_step;
  logic                         harmonic_mode;
  logic signed [AMP_CFG_W-1:0]  base_amplitude;
  logic signed [AMP_CFG_W-1:0]  amplitude_decrement;
  logic [GAIN_W-1:0]            velocity_gain;

  // trajectory state
  logic [PHASE_W-1:0] phase_acc;
  logic               finished;

  // per-tick datapath
  logic [PHASE_W-1:0]       tick_phase;
  logic signed [TRIG_W-1:0] c1;
  logic signed [TRIG_W-1:0] s1;
  logic signed [TRIG_W-1:0] c3;
  logic signed [TRIG_W-1:0] s3;
  logic signed [CS_W-1:0]   cs;
  logic signed [CS_W-1:0]   ss;
  logic signed [GS_W-1:0]   gs;
  logic signed [AMP_W-1:0]  amp;
  logic [MOTOR_W-1:0]       motor;
  logic signed [PPROD_W-1:0] pos_prod;
  logic signed [ACC_W-1:0]  acc;

  logic                 accept;
  logic [PHASE_W-1:0]   ph_eff;
  logic                 fin_eff;
  logic [PHASE_W:0]     step_sum;
  logic [PHASE_W-1:0]   phase3;
  logic                 last_motor;
  logic                 out_load;

  logic                 cd_start;
  logic [PHASE_W-1:0]   cd_phase;
  ctg_trig_t            trig;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  logic signed [PRND_W-1:0] pos_rnd;
  logic signed [PRND_W-1:0] pos_sh;
  logic signed [POS_W-1:0]  pos_val;
  logic signed [ACC_W-1:0]  vel_rnd;
  logic signed [ACC_W-1:0]  vel_sh;
  logic signed [VEL_W-1:0]  vel_val;

  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign ph_eff     = s_tdata[0] ? '0 : phase_acc;
  assign fin_eff    = s_tdata[0] ? 1'b0 : finished;
  assign step_sum   = {1'b0, ph_eff} + {1'b0, phase_step};
  assign phase3     = tick_phase + {tick_phase[PHASE_W-2:0], 1'b0};
  assign last_motor = (motor == MOTOR_W'(NUM_MOTORS - 1));
  assign out_load   = (state == S_OUT) && (!m_tvalid || m_tready);

  // CORDIC launch: tick phase from idle, tripled phase for the harmonic
  always_comb begin
    cd_start = 1'b0;
    cd_phase = ph_eff;
    if (state == S_IDLE) begin
      cd_start = accept && !fin_eff;
    end else if (state == S_COS1) begin
      cd_start = trig.done && harmonic_mode;
      cd_phase = phase3;
    end
  end

  ctg_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .start(cd_start),
    .phase(cd_phase),
    .trig (trig)
  );

  // operand selection for the shared multiplier; product lands one state later
  always_comb begin
    unique case (state)
      S_GAIN: begin
        mul_a = {2'b00, velocity_gain};
        mul_b = MUL_W'(ss);
      end
      S_MPOS: begin
        mul_a = MUL_W'(amp);
        mul_b = MUL_W'(cs);
      end
      S_MHI: begin
        mul_a = MUL_W'(amp);
        mul_b = MUL_W'($signed(gs[GS_W-1:GS_LO_W]));
      end
      S_MLO: begin
        mul_a = MUL_W'(amp);
        mul_b = {3'b000, gs[GS_LO_W-1:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ctg_mult u_mult (
    .clk  (clk),
    .mul_a(mul_a),
    .mul_b(mul_b),
    .prod (prod)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept && !fin_eff) state_next = S_COS1;
      S_COS1: if (trig.done) state_next = harmonic_mode ? S_COS3 : S_SUM;
      S_COS3: if (trig.done) state_next = S_SUM;
      S_SUM:  state_next = S_GAIN;
      S_GAIN: state_next = S_GS;
      S_GS:   state_next = S_MPOS;
      S_MPOS: state_next = S_MHI;
      S_MHI:  state_next = S_MLO;
      S_MLO:  state_next = S_ACC;
      S_ACC:  state_next = S_OUT;
      S_OUT:  if (out_load) state_next = last_motor ? S_IDLE : S_MPOS;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      phase_acc           <= '0;
      finished            <= 1'b0;
      motor               <= '0;
      m_tvalid            <= 1'b0;
      phase_step          <= PHASE_STEP_RST;
      harmonic_mode       <= HARMONIC_RST;
      base_amplitude      <= BASE_AMP_RST;
      amplitude_decrement <= AMP_DEC_RST;
      velocity_gain       <= VEL_GAIN_RST;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_PHASE_STEP:    phase_step          <= cfg_wdata[31:0];
          CFG_HARMONIC_MODE: harmonic_mode       <= cfg_wdata[0];
          CFG_BASE_AMP:      base_amplitude      <= cfg_wdata[AMP_CFG_W-1:0];
          CFG_AMP_DEC:       amplitude_decrement <= cfg_wdata[AMP_CFG_W-1:0];
          CFG_VEL_GAIN:      velocity_gain       <= cfg_wdata[GAIN_W-1:0];
          default: ;
        endcase
      end

      // phase advances as the tick is taken unless it would wrap; a wrap ends the trajectory
      if (accept && !fin_eff) begin
        finished  <= step_sum[PHASE_W];
        phase_acc <= step_sum[PHASE_W] ? ph_eff : step_sum[PHASE_W-1:0];
      end

      if (state == S_SUM) begin
        motor <= '0;
      end else if (out_load) begin
        motor <= motor + 1'b1;
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // rounding and saturation of the finished products
  always_comb begin
    pos_rnd = PRND_W'(pos_prod) + PRND_W'(16384);
    pos_sh  = pos_rnd >>> 15;
    if (pos_sh > PRND_W'(131071)) begin
      pos_val = POS_W'(131071);
    end else if (pos_sh < -PRND_W'(131072)) begin
      pos_val = -POS_W'(131072);
    end else begin
      pos_val = pos_sh[POS_W-1:0];
    end

    vel_rnd = (ACC_W'(1) <<< 30) - acc;
    vel_sh  = vel_rnd >>> 31;
    if (vel_sh > ACC_W'(64'sh7FFF_FFFF)) begin
      vel_val = 32'sh7FFF_FFFF;
    end else if (vel_sh < -ACC_W'(64'sh8000_0000)) begin
      vel_val = 32'sh8000_0000;
    end else begin
      vel_val = vel_sh[VEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tick_phase <= ph_eff;
    end
    if (state == S_COS1 && trig.done) begin
      c1 <= trig.cos_val;
      s1 <= trig.sin_val;
      c3 <= '0;
      s3 <= '0;
    end
    if (state == S_COS3 && trig.done) begin
      c3 <= trig.cos_val;
      s3 <= trig.sin_val;
    end
    if (state == S_SUM) begin
      cs  <= CS_W'(c1) + CS_W'(c3);
      ss  <= CS_W'(s1) + CS_W'(s3) + (CS_W'(s3) <<< 1);
      amp <= AMP_W'(base_amplitude);
    end
    if (state == S_GS) begin
      gs <= prod[GS_W-1:0];
    end
    if (state == S_MHI) begin
      pos_prod <= prod[PPROD_W-1:0];
    end
    // velocity product = gs_hi * amp * 2^19 + gs_lo * amp
    if (state == S_MLO) begin
      acc <= ACC_W'(prod) <<< GS_LO_W;
    end
    if (state == S_ACC) begin
      acc <= acc + ACC_W'(prod);
    end
    if (out_load) begin
      m_tdata <= {2'b00, vel_val, pos_val, motor};
      m_tlast <= last_motor;
      amp     <= amp - AMP_W'(amplitude_decrement);
    end
  end

`ifndef ASSERT_OFF
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    trig.done |-> (state == S_COS1 || state == S_COS3))
    else $error("CORDIC finished outside a wait state");

  a_motor_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MPOS) |-> ({1'b0, motor} < (MOTOR_W + 1)'(NUM_MOTORS)))
    else $error("motor counter beyond motor count");

  a_finished_hold: assert property (@(posedge clk) disable iff (rst)
    (finished && !(accept && s_tdata[0])) |=> (finished && $stable(phase_acc)))
    else $error("finished trajectory changed without restart");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && last_motor) |=> s_tready)
    else $error("tick not closed after last motor");
`endif

endmodule

### src/ctg_mult.sv
`timescale 1ns / 1ps

module ctg_mult
  import ctg_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  mul_a,
  input  logic signed [MUL_W-1:0]  mul_b,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

endmodule

### src/ctg_cordic.sv
`timescale 1ns / 1ps

module ctg_cordic
  import ctg_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [PHASE_W-1:0] phase,
  output ctg_trig_t          trig
);

  localparam int ITER_W = $clog2(CORDIC_STEPS);

  logic signed [XY_W-1:0] x;
  logic signed [XY_W-1:0] y;
  logic signed [Z_W-1:0]  z;
  logic [1:0]             quad;
  logic [ITER_W-1:0]      iter;
  logic                   busy;
  logic                   done;

  logic signed [XY_W-1:0]   xs;
  logic signed [XY_W-1:0]   ys;
  logic signed [Z_W-1:0]    atan_val;
  logic signed [TRIG_W-1:0] xc;
  logic signed [TRIG_W-1:0] yc;

  function automatic logic signed [TRIG_W-1:0] sat_trig(input logic signed [XY_W-1:0] v);
    logic signed [TRIG_W-1:0] r;
    if (v > XY_W'(TRIG_MAX)) begin
      r = TRIG_W'(TRIG_MAX);
    end else if (v < -XY_W'(TRIG_MAX)) begin
      r = -TRIG_W'(TRIG_MAX);
    end else begin
      r = v[TRIG_W-1:0];
    end
    return r;
  endfunction

  assign xs       = x >>> iter;
  assign ys       = y >>> iter;
  assign atan_val = atan_turn(ATAN_IDX_W'(iter));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + 1'b1;
        if (iter == ITER_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= XY_W'(CORDIC_X0);
      y    <= '0;
      z    <= {2'b00, phase[PHASE_W-3:0]};
      quad <= phase[PHASE_W-1:PHASE_W-2];
    end else if (busy) begin
      // rotate towards z = 0
      if (!z[Z_W-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_val;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_val;
      end
    end
  end

  assign xc = sat_trig(x);
  assign yc = sat_trig(y);

  always_comb begin
    trig.done = done;
    unique case (quad)
      2'd0: begin
        trig.cos_val = xc;
        trig.sin_val = yc;
      end
      2'd1: begin
        trig.cos_val = -yc;
        trig.sin_val = xc;
      end
      2'd2: begin
        trig.cos_val = -xc;
        trig.sin_val = -yc;
      end
      default: begin
        trig.cos_val = yc;
        trig.sin_val = -xc;
      end
    endcase
  end

endmodule
